/* rtl/cld_pkg.sv */
// Shared types and constants of the Content-Length deframer.
// Holds the header text table, separator codes and the body beat type.
// No dependencies.
package cld_pkg;

  localparam int unsigned HDR_LEN       = 15;
  localparam int unsigned PAYLOAD_LEN_W = 24;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = 1;
  localparam int unsigned QCNT_W        = 2;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [4:0] {
    MODE_HUNT  = 5'b00001,
    MODE_BLANK = 5'b00010,
    MODE_DIGIT = 5'b00100,
    MODE_SEP   = 5'b01000,
    MODE_BODY  = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [7:0]               data;
    logic                     last;
    logic [PAYLOAD_LEN_W-1:0] length;
  } beat_t;

  // Header text "Content-Length:", one character per index.
  function automatic logic [7:0] hdr_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/content_length_deframer.sv */
// Content-Length message deframer, top level.
// Instantiates cld_front, cld_queue and cld_back; uses cld_pkg.
//
// One received byte is taken per cycle on the in_* channel while in_ready_o
// is high. The parser hunts for "Content-Length:", skips spaces and tabs,
// gathers a decimal length of up to LEN_BITS bits, expects CR LF CR LF and
// then forwards exactly that many body bytes on the out_* channel, one beat
// per byte, with last_byte_o on the final one and payload_length_o carrying
// the decoded length (low 24 bits). A zero length, a wrong separator byte or
// a length overflow drops back to the hunt; the offending byte is examined
// again as a header start. Rate: one byte per cycle sustained while
// in_ready_o is high; every parser decision is a registered state update.
// Body beats pass through a two-entry queue and an output register: a beat
// enters the queue at the edge that accepts its byte and moves on to the
// output register when that is empty or being drained. in_ready_o falls only
// when the queue is full, which happens only after out_ready_i was held low.
module content_length_deframer #(
  parameter int unsigned LEN_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  payload_byte_o,
  output logic        last_byte_o,
  output logic [23:0] payload_length_o
);

  logic           in_accept;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;
  cld_pkg::beat_t front_beat;
  cld_pkg::beat_t q_beat;
  cld_pkg::beat_t out_beat;

  // Take a byte whenever the queue has room; non-body bytes only update state.
  assign in_ready_o = !q_full;
  assign in_accept  = in_valid_i && in_ready_o;

  cld_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (in_byte_i),
    .push_o   (push),
    .beat_o   (front_beat)
  );

  cld_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .beat_i  (front_beat),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .beat_o  (q_beat)
  );

  cld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_beat_i    (q_beat),
    .pop_o       (pop),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat)
  );

  // Drive the body beat fields as ports of their own.
  assign payload_byte_o   = out_beat.data;
  assign last_byte_o      = out_beat.last;
  assign payload_length_o = out_beat.length;

endmodule

/* rtl/cld_front.sv */
// Front end of the deframer: header hunt, length parse, separator match.
// Pushes one beat per body byte into the queue. Uses cld_pkg.
module cld_front #(
  parameter int unsigned LEN_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    byte_i,
  output logic          push_o,
  output cld_pkg::beat_t beat_o
);

  localparam logic [3:0] HDR_LAST = 4'(cld_pkg::HDR_LEN - 1);
  localparam int unsigned PAYLOAD_PAD = cld_pkg::PAYLOAD_LEN_W;

  cld_pkg::mode_e      mode_q, mode_d;
  logic [3:0]          pos_q, pos_d;
  logic [LEN_BITS-1:0] acc_q, acc_d;
  logic [LEN_BITS-1:0] rem_q, rem_d;

  logic [LEN_BITS+3:0] acc_x10;
  logic                is_digit;
  logic                is_blank;
  logic                ovf;
  logic                last;
  logic                restart;
  logic [3:0]          hunt_p;
  logic [4:0]          hunt_cur;
  logic [4:0]          hunt_zero;
  logic [LEN_BITS+PAYLOAD_PAD-1:0] acc_ext;

  // Bit 4: header complete; bits 3:0: next match position.
  function automatic logic [4:0] hunt_next(input logic [7:0] b, input logic [3:0] p);
    logic [4:0] r;
    if (b == cld_pkg::hdr_char(p)) begin
      if (p == HDR_LAST) begin
        r = 5'b10000;
      end else begin
        r = {1'b0, p + 4'd1};
      end
    end else begin
      r = {1'b0, 3'd0, (b == cld_pkg::hdr_char(4'd0))};
    end
    return r;
  endfunction

  assign is_digit = (byte_i >= cld_pkg::CHAR_ZERO) && (byte_i <= cld_pkg::CHAR_NINE);
  assign is_blank = (byte_i == cld_pkg::CHAR_SPACE) || (byte_i == cld_pkg::CHAR_TAB);
  assign acc_x10  = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
                  + {{LEN_BITS{1'b0}}, byte_i[3:0]};
  assign ovf      = |acc_x10[LEN_BITS+3:LEN_BITS];
  assign last     = (rem_q <= LEN_BITS'(1));

  assign hunt_p    = ((mode_q == cld_pkg::MODE_HUNT) && (pos_q <= HDR_LAST)) ? pos_q : 4'd0;
  assign hunt_cur  = hunt_next(byte_i, hunt_p);
  assign hunt_zero = hunt_next(byte_i, 4'd0);

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    push_o  = 1'b0;
    restart = 1'b0;
    if (accept_i) begin
      unique case (mode_q)
        cld_pkg::MODE_BODY: begin
          push_o = 1'b1;
          if (last) begin
            rem_d  = '0;
            mode_d = cld_pkg::MODE_HUNT;
            pos_d  = 4'd0;
          end else begin
            rem_d = rem_q - LEN_BITS'(1);
          end
        end
        cld_pkg::MODE_SEP: begin
          if (byte_i == (pos_q[0] ? cld_pkg::CHAR_LF : cld_pkg::CHAR_CR)) begin
            if (pos_q[1:0] == 2'd3) begin
              mode_d = cld_pkg::MODE_BODY;
              rem_d  = acc_q;
              pos_d  = 4'd0;
            end else begin
              pos_d = {2'd0, pos_q[1:0] + 2'd1};
            end
          end else begin
            restart = 1'b1;
          end
        end
        cld_pkg::MODE_BLANK, cld_pkg::MODE_DIGIT: begin
          if (!((mode_q == cld_pkg::MODE_BLANK) && is_blank)) begin
            mode_d = cld_pkg::MODE_DIGIT;
            if (is_digit) begin
              if (ovf) begin
                restart = 1'b1;
              end else begin
                acc_d = acc_x10[LEN_BITS-1:0];
              end
            end else if (acc_q == '0) begin
              restart = 1'b1;
            end else if (byte_i == cld_pkg::CHAR_CR) begin
              // first separator byte seen right after the digits
              mode_d = cld_pkg::MODE_SEP;
              pos_d  = 4'd1;
            end else begin
              restart = 1'b1;
            end
          end
        end
        default: begin
          mode_d = hunt_cur[4] ? cld_pkg::MODE_BLANK : cld_pkg::MODE_HUNT;
          pos_d  = hunt_cur[3:0];
          if (hunt_cur[4]) begin
            acc_d = '0;
          end
        end
      endcase
      // re-examine the offending byte as the start of a header
      if (restart) begin
        mode_d = hunt_zero[4] ? cld_pkg::MODE_BLANK : cld_pkg::MODE_HUNT;
        pos_d  = hunt_zero[3:0];
        if (hunt_zero[4]) begin
          acc_d = '0;
        end
      end
    end
  end

  assign acc_ext = {{PAYLOAD_PAD{1'b0}}, acc_q};

  assign beat_o.data   = byte_i;
  assign beat_o.last   = last;
  assign beat_o.length = acc_ext[cld_pkg::PAYLOAD_LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cld_pkg::MODE_HUNT;
      pos_q  <= 4'd0;
      acc_q  <= '0;
      rem_q  <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      acc_q  <= acc_d;
      rem_q  <= rem_d;
    end
  end

endmodule

/* rtl/cld_queue.sv */
// Two-entry beat queue between the parser and the output stage.
// Uses cld_pkg for the beat type and depth.
module cld_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cld_pkg::beat_t beat_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output cld_pkg::beat_t beat_o
);

  cld_pkg::beat_t            mem_q [cld_pkg::QUEUE_DEPTH];
  logic [cld_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [cld_pkg::QCNT_W-1:0] count_q;

  assign full_o  = (count_q == cld_pkg::QCNT_W'(cld_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign beat_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + cld_pkg::QCNT_W'(1);
        2'b01:   count_q <= count_q - cld_pkg::QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* rtl/cld_back.sv */
// Output stage: holds one body beat for the downstream consumer.
// Pops the queue whenever the register is empty or being drained. Uses cld_pkg.
module cld_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  cld_pkg::beat_t q_beat_i,
  output logic           pop_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output cld_pkg::beat_t out_beat_o
);

  logic           valid_q;
  cld_pkg::beat_t beat_q;

  assign pop_o       = q_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      beat_q <= q_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

/* rtl/cld_checker.sv */
// Port-level checks of the deframer, bound to the top level.
// Depends on content_length_deframer's port list and LEN_BITS parameter only.
module cld_checker #(
  parameter int unsigned LEN_BITS = 24
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  in_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  payload_byte_o,
  input logic        last_byte_o,
  input logic [23:0] payload_length_o
);

  logic        mid_msg_q;
  logic [23:0] prev_len_q;
  logic        out_acc;

  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_msg_q  <= 1'b0;
      prev_len_q <= '0;
    end else if (out_acc) begin
      mid_msg_q  <= !last_byte_o;
      prev_len_q <= payload_length_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(last_byte_o) && $stable(payload_length_o))
    else $error("stalled output beat changed");

  // The asynchronous reset clears the output register's valid flag.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  a_len_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (LEN_BITS <= 24) && (payload_length_o == 24'd1) |-> last_byte_o)
    else $error("one-byte message not marked last");

  a_len_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && mid_msg_q |-> payload_length_o == prev_len_q)
    else $error("length changed inside a message");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (LEN_BITS <= 24) |-> payload_length_o != 24'd0)
    else $error("body beat with zero length");

  logic unused_in;
  assign unused_in = ^{in_valid_i, in_ready_o, in_byte_i};

endmodule

bind content_length_deframer cld_checker #(
  .LEN_BITS (LEN_BITS)
) u_cld_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .in_byte_i        (in_byte_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .payload_byte_o   (payload_byte_o),
  .last_byte_o      (last_byte_o),
  .payload_length_o (payload_length_o)
);
